@@ hdl/pvp_pkg.sv @@
package pvp_pkg;

  localparam int POSE_WORDS = 12;
  localparam int DIV_ITER   = 32;
  // prep stage, one stage per quotient bit, saturating output stage
  localparam int DIV_LAT    = DIV_ITER + 2;

  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_PROJECT = 1'b1;

  localparam logic [1:0] ST_BEHIND  = 2'd0;
  localparam logic [1:0] ST_OFF     = 2'd1;
  localparam logic [1:0] ST_VISIBLE = 2'd2;

  localparam logic [2:0] REG_FOCAL_X      = 3'd0;
  localparam logic [2:0] REG_FOCAL_Y      = 3'd1;
  localparam logic [2:0] REG_CENTER_X     = 3'd2;
  localparam logic [2:0] REG_CENTER_Y     = 3'd3;
  localparam logic [2:0] REG_IMAGE_WIDTH  = 3'd4;
  localparam logic [2:0] REG_IMAGE_HEIGHT = 3'd5;

  localparam logic [31:0] FOCAL_RESET    = 32'h01F4_0000;
  localparam logic [31:0] CENTER_X_RESET = 32'h0140_0000;
  localparam logic [31:0] CENTER_Y_RESET = 32'h00F0_0000;
  localparam logic [15:0] WIDTH_RESET    = 16'd640;
  localparam logic [15:0] HEIGHT_RESET   = 16'd480;

  typedef struct packed {
    logic [5:0]         cam;
    logic               behind;
    logic signed [31:0] cx;
    logic signed [31:0] cy;
    logic signed [31:0] cz;
  } side_t;

endpackage

@@ hdl/pinhole_vertex_projection.sv @@
// pinhole vertex projection
// input channel: in_valid / in_stall with opcode, camera_index, word_index,
// pose_word and vertex_x/y/z. a write item (opcode 0) stores one pose word of
// a camera in the pose memory and gives no result. a project item (opcode 1)
// reads the camera's twelve pose words, transforms the vertex into camera
// space, divides by depth and scales to pixels.
// output channel: out_valid / out_stall with result_camera, status,
// camera_x/y/z and pixel_u/v, one item per project item, in order.
// configuration: cfg_write with cfg_index and cfg_data writes the focal
// lengths, principal point and image size; the user must write it only
// while the block is idle, which the block itself does not enforce.
// throughput: one item per cycle while out_stall is low. the 40 stages are
// read, multiply, sum, round, the 34-stage radix-2 divider, scale, output.
// each stage holds its item while the next stage is full and stalled, so
// bubbles close up; in_stall rises only once every stage is full.
// reset clears the valid bits and configuration registers; the pose memory
// is not cleared and a pose word must be written before it is used.
module pinhole_vertex_projection
  import pvp_pkg::*;
#(
  parameter int MAX_CAMERAS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               opcode,
  input  logic [5:0]         camera_index,
  input  logic [3:0]         word_index,
  input  logic signed [31:0] pose_word,
  input  logic signed [31:0] vertex_x,
  input  logic signed [31:0] vertex_y,
  input  logic signed [31:0] vertex_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [5:0]         result_camera,
  output logic [1:0]         status,
  output logic signed [31:0] camera_x,
  output logic signed [31:0] camera_y,
  output logic signed [31:0] camera_z,
  output logic [31:0]        pixel_u,
  output logic [31:0]        pixel_v,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  localparam int AW    = (MAX_CAMERAS > 1) ? $clog2(MAX_CAMERAS) : 1;
  localparam int S_DIV = 4;
  localparam int S_MUL = S_DIV + DIV_LAT;
  localparam int NST   = S_MUL + 2;
  localparam logic [66:0] ROUND_HALF = 67'd1 << 29;

  // configuration
  logic [31:0] focal_x, focal_y, center_x, center_y;
  logic [15:0] image_width, image_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      focal_x      <= FOCAL_RESET;
      focal_y      <= FOCAL_RESET;
      center_x     <= CENTER_X_RESET;
      center_y     <= CENTER_Y_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FOCAL_X:      focal_x      <= cfg_data;
        REG_FOCAL_Y:      focal_y      <= cfg_data;
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Y:     center_y     <= cfg_data;
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[15:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // stage handshake
  logic [NST-1:0] vld;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid && opcode == OP_PROJECT;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) vld[k] <= vld[k-1];
      end
    end
  end

  // pose memory, one row of twelve words per camera
  logic [POSE_WORDS-1:0][31:0] pose_mem [MAX_CAMERAS];
  logic [10:0]   cam_ext;
  logic [AW-1:0] addr;
  logic          in_range;
  logic          accept;

  assign cam_ext  = {5'b0, camera_index};
  assign addr     = cam_ext[AW-1:0];
  assign in_range = cam_ext < 11'(MAX_CAMERAS);
  assign accept   = in_valid && en[0];

  // write lands at the accept edge; later project items read the new word
  always_ff @(posedge clk) begin
    if (accept && opcode == OP_WRITE && in_range && word_index < 4'(POSE_WORDS)) begin
      pose_mem[addr][word_index] <= pose_word;
    end
  end

  // stage 1: row read
  logic [POSE_WORDS-1:0][31:0] rd_row;
  logic [5:0]         s1_cam;
  logic               s1_oor;
  logic signed [31:0] s1_v [3];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rd_row  <= pose_mem[addr];
      s1_cam  <= camera_index;
      s1_oor  <= !in_range;
      s1_v[0] <= vertex_x;
      s1_v[1] <= vertex_y;
      s1_v[2] <= vertex_z;
    end
  end

  // stage 2: nine rotation products
  logic signed [31:0] mw [POSE_WORDS];
  logic signed [63:0] prod [9];
  logic signed [31:0] trans [3];
  logic [5:0]         s2_cam;

  always_comb begin
    for (int i = 0; i < POSE_WORDS; i++) begin
      mw[i] = s1_oor ? 32'sd0 : $signed(rd_row[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          prod[r*3+k] <= mw[r*4+k] * s1_v[k];
        end
        trans[r] <= mw[r*4+3];
      end
      s2_cam <= s1_cam;
    end
  end

  // stage 3: exact row sums in Q.46 with rounding half
  logic signed [66:0] rsum [3];
  logic [5:0]         s3_cam;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        rsum[r] <= $signed({{3{prod[r*3][63]}}, prod[r*3]})
                 + $signed({{3{prod[r*3+1][63]}}, prod[r*3+1]})
                 + $signed({{3{prod[r*3+2][63]}}, prod[r*3+2]})
                 + $signed({{5{trans[r][31]}}, trans[r], 30'b0})
                 + $signed(ROUND_HALF);
      end
      s3_cam <= s2_cam;
    end
  end

  // stage 4: floor to Q16.16 and saturate
  logic signed [31:0] cc [3];
  logic [36:0]        rfl [3];
  logic [5:0]         s4_cam;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      rfl[r] = rsum[r][66:30];
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int r = 0; r < 3; r++) begin
        if (rfl[r][36:31] == {6{rfl[r][31]}}) begin
          cc[r] <= $signed(rfl[r][31:0]);
        end else if (rfl[r][36]) begin
          cc[r] <= 32'sh8000_0000;
        end else begin
          cc[r] <= 32'sh7FFF_FFFF;
        end
      end
      s4_cam <= s3_cam;
    end
  end

  // divider stages: x / z and y / z
  side_t              side [DIV_LAT];
  logic signed [31:0] quot_x, quot_y;

  pvp_div u_div_x (
    .clk  (clk),
    .en   (en[S_DIV +: DIV_LAT]),
    .num  (cc[0]),
    .den  (cc[2]),
    .quot (quot_x)
  );

  pvp_div u_div_y (
    .clk  (clk),
    .en   (en[S_DIV +: DIV_LAT]),
    .num  (cc[1]),
    .den  (cc[2]),
    .quot (quot_y)
  );

  always_ff @(posedge clk) begin
    if (en[S_DIV]) begin
      side[0].cam    <= s4_cam;
      side[0].behind <= cc[2][31] || cc[2] == 32'sd0;
      side[0].cx     <= cc[0];
      side[0].cy     <= cc[1];
      side[0].cz     <= cc[2];
    end
    for (int k = 1; k < DIV_LAT; k++) begin
      if (en[S_DIV+k]) side[k] <= side[k-1];
    end
  end

  // focal scaling
  logic signed [64:0] mul_u, mul_v;
  side_t              s5_side;

  always_ff @(posedge clk) begin
    if (en[S_MUL]) begin
      mul_u   <= $signed({1'b0, focal_x}) * quot_x;
      mul_v   <= $signed({1'b0, focal_y}) * quot_y;
      s5_side <= side[DIV_LAT-1];
    end
  end

  // floor, add principal point, bound test and clamp
  logic [49:0] pu, pv;
  logic        vis_u, vis_v;
  logic [31:0] pu_c, pv_c;

  always_comb begin
    pu    = {mul_u[64], mul_u[64:16]} + {18'b0, center_x};
    pv    = {mul_v[64], mul_v[64:16]} + {18'b0, center_y};
    vis_u = !pu[49] && pu < {18'b0, image_width, 16'b0};
    vis_v = !pv[49] && pv < {18'b0, image_height, 16'b0};
    if (pu[49])              pu_c = '0;
    else if (pu[48:32] != '0) pu_c = '1;
    else                     pu_c = pu[31:0];
    if (pv[49])              pv_c = '0;
    else if (pv[48:32] != '0) pv_c = '1;
    else                     pv_c = pv[31:0];
  end

  always_ff @(posedge clk) begin
    if (en[NST-1]) begin
      result_camera <= s5_side.cam;
      camera_x      <= s5_side.cx;
      camera_y      <= s5_side.cy;
      camera_z      <= s5_side.cz;
      if (s5_side.behind) begin
        status  <= ST_BEHIND;
        pixel_u <= '0;
        pixel_v <= '0;
      end else begin
        status  <= (vis_u && vis_v) ? ST_VISIBLE : ST_OFF;
        pixel_u <= pu_c;
        pixel_v <= pv_c;
      end
    end
  end

endmodule

@@ hdl/pvp_div.sv @@
module pvp_div
  import pvp_pkg::*;
(
  input  logic                      clk,
  input  logic [DIV_LAT-1:0]        en,
  input  logic signed [31:0]        num,
  input  logic [31:0]               den,
  output logic signed [31:0]        quot
);

  logic [31:0] rem   [DIV_ITER+1];
  logic [31:0] dlow  [DIV_ITER+1];
  logic [31:0] q     [DIV_ITER+1];
  logic [31:0] dv    [DIV_ITER+1];
  logic        neg   [DIV_ITER+1];
  logic        ovf   [DIV_ITER+1];

  logic [31:0] mag;
  logic [32:0] trial [DIV_ITER+1];
  logic [32:0] diff  [DIV_ITER+1];

  assign mag = num[31] ? 32'(-num) : 32'(num);

  always_comb begin
    trial[0] = '0;
    diff[0]  = '0;
    for (int k = 1; k <= DIV_ITER; k++) begin
      trial[k] = {rem[k-1], dlow[k-1][31]};
      diff[k]  = trial[k] - {1'b0, dv[k-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      // dividend is mag * 2^16; quotient fits 32 bits unless mag >= den * 2^16
      rem[0]  <= {16'b0, mag[31:16]};
      dlow[0] <= {mag[15:0], 16'b0};
      q[0]    <= '0;
      dv[0]   <= den;
      neg[0]  <= num[31];
      ovf[0]  <= {16'b0, mag} >= {den, 16'b0};
    end
    for (int k = 1; k <= DIV_ITER; k++) begin
      if (en[k]) begin
        if (!diff[k][32]) begin
          rem[k] <= diff[k][31:0];
          q[k]   <= {q[k-1][30:0], 1'b1};
        end else begin
          rem[k] <= trial[k][31:0];
          q[k]   <= {q[k-1][30:0], 1'b0};
        end
        dlow[k] <= {dlow[k-1][30:0], 1'b0};
        dv[k]   <= dv[k-1];
        neg[k]  <= neg[k-1];
        ovf[k]  <= ovf[k-1];
      end
    end
    if (en[DIV_LAT-1]) begin
      if (neg[DIV_ITER]) begin
        if (ovf[DIV_ITER] || q[DIV_ITER] > 32'h8000_0000) begin
          quot <= 32'sh8000_0000;
        end else begin
          quot <= $signed(32'(-q[DIV_ITER]));
        end
      end else begin
        if (ovf[DIV_ITER] || q[DIV_ITER][31]) begin
          quot <= 32'sh7FFF_FFFF;
        end else begin
          quot <= $signed(q[DIV_ITER]);
        end
      end
    end
  end

endmodule
